// ===== rtl/nlaf_pkg.sv =====
// Package for the netlink attribute finder: item structs, walk phases and constants.
// Used by every module under rtl; depends on nothing.
package nlaf_pkg;

	localparam int unsigned FIXED_HDR_BYTES = 20;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW = 2;

	typedef enum logic [1:0] {
		CFG_WANTED_TYPE = 2'd0,
		CFG_USER_HDR_LEN = 2'd1,
		CFG_MAX_COPY = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_REC_HDR,
		PH_SKIP,
		PH_MATCH,
		PH_DONE
	} walk_phase_t;

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  value_byte;
		logic        value_valid;
		logic        done_res;
		logic        header_ok;
		logic        found;
		logic [15:0] value_length;
	} out_item_t;

	// Byte tagged by the front end with its place in the message.
	typedef struct packed {
		logic [7:0]  msg_byte;
		logic        last_byte;
		logic [31:0] offset;
	} tagged_byte_t;

endpackage

// ===== rtl/nlaf_front.sv =====
// Front end of the attribute finder: accepts bytes, tags each with its offset.
// Depends on nlaf_pkg.
module nlaf_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  nlaf_pkg::in_item_t    in_item,
	output logic                  q_valid,
	input  logic                  q_ready,
	output nlaf_pkg::tagged_byte_t q_item
);

	logic [31:0] offset_q;
	logic        accept;

	assign in_ready = q_ready;
	assign q_valid = in_valid;
	assign accept = in_valid && q_ready;
	assign q_item.msg_byte = in_item.msg_byte;
	assign q_item.last_byte = in_item.last_byte;
	assign q_item.offset = offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (accept) begin
			if (in_item.last_byte) begin
				offset_q <= '0;
			end else if (offset_q != 32'hFFFF_FFFF) begin
				offset_q <= offset_q + 32'd1;
			end
		end
	end

endmodule

// ===== rtl/nlaf_queue.sv =====
// Short queue between front and back end of the attribute finder.
// Depends on nlaf_pkg.
module nlaf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_valid,
	output logic                   wr_ready,
	input  nlaf_pkg::tagged_byte_t wr_item,
	output logic                   rd_valid,
	input  logic                   rd_ready,
	output nlaf_pkg::tagged_byte_t rd_item
);

	nlaf_pkg::tagged_byte_t entry_q [nlaf_pkg::QUEUE_DEPTH];
	logic [nlaf_pkg::QUEUE_AW-1:0] wptr_q;
	logic [nlaf_pkg::QUEUE_AW-1:0] rptr_q;
	logic [nlaf_pkg::QUEUE_AW:0]   count_q;
	logic                          push;
	logic                          pop;

	assign wr_ready = (count_q != (nlaf_pkg::QUEUE_AW+1)'(nlaf_pkg::QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item = entry_q[rptr_q];
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (nlaf_pkg::QUEUE_AW+1)'(nlaf_pkg::QUEUE_DEPTH))
		else $error("queue count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == (nlaf_pkg::QUEUE_AW+1)'(nlaf_pkg::QUEUE_DEPTH)) |-> !push)
		else $error("push into full queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wptr_q - rptr_q) == count_q[nlaf_pkg::QUEUE_AW-1:0])
		else $error("queue pointers disagree with count");

endmodule

// ===== rtl/nlaf_back.sv =====
// Back end of the attribute finder: header checks, record walk and output register.
// Depends on nlaf_pkg.
module nlaf_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  nlaf_pkg::tagged_byte_t q_item,
	input  logic [13:0]            wanted_type,
	input  logic [7:0]             user_header_len,
	input  logic [15:0]            max_copy,
	output logic                   out_valid,
	input  logic                   out_ready,
	output nlaf_pkg::out_item_t    out_item
);

	nlaf_pkg::walk_phase_t phase_q, phase_d;
	logic [31:0] decl_len_q, decl_len_d;
	logic        hdr_good_q, hdr_good_d;
	logic [15:0] rec_len_q, rec_len_d;
	logic [15:0] rec_type_q, rec_type_d;
	logic [15:0] left_q, left_d;
	logic        match_seen_q, match_seen_d;
	logic        match_done_q, match_done_d;
	logic [15:0] match_len_q, match_len_d;

	logic                out_valid_q;
	nlaf_pkg::out_item_t out_q;

	logic        take;
	logic [31:0] o;
	logic [7:0]  b;
	logic [9:0]  attr_start;
	logic        past_end;
	logic [1:0]  idx;
	logic [15:0] full_len;
	logic [15:0] full_type;
	logic [32:0] rec_end;
	logic [16:0] rounded;
	logic        vv;
	logic        emit;
	logic        found_w;

	assign q_ready = !out_valid_q || out_ready;
	assign take = q_valid && q_ready;
	assign o = q_item.offset;
	assign b = q_item.msg_byte;
	assign attr_start = 10'(nlaf_pkg::FIXED_HDR_BYTES)
		+ 10'({({2'b0, user_header_len} + 10'd3) >> 2, 2'b00});
	assign past_end = (o >= decl_len_d);
	assign idx = 2'(3'd4 - left_q[2:0]);

	always_comb begin
		phase_d = phase_q;
		decl_len_d = decl_len_q;
		hdr_good_d = hdr_good_q;
		rec_len_d = rec_len_q;
		rec_type_d = rec_type_q;
		left_d = left_q;
		match_seen_d = match_seen_q;
		match_done_d = match_done_q;
		match_len_d = match_len_q;
		vv = 1'b0;
		full_len = rec_len_q;
		full_type = rec_type_q;
		rec_end = '0;
		rounded = '0;

		case (o)
			32'd0: decl_len_d = {decl_len_q[31:8], b};
			32'd1: decl_len_d = {decl_len_q[31:16], b, decl_len_q[7:0]};
			32'd2: decl_len_d = {decl_len_q[31:24], b, decl_len_q[15:0]};
			32'd3: decl_len_d = {b, decl_len_q[23:0]};
			default: decl_len_d = decl_len_q;
		endcase
		if (o == 32'd3) begin
			hdr_good_d = (decl_len_d >= {22'd0, attr_start});
		end

		case (phase_q)
			nlaf_pkg::PH_HEADER: begin
				if ((33'(o) + 33'd1 >= 33'(attr_start)) && (o >= 32'd3)) begin
					if (hdr_good_d) begin
						phase_d = nlaf_pkg::PH_REC_HDR;
						left_d = 16'd4;
						rec_len_d = '0;
						rec_type_d = '0;
					end else begin
						phase_d = nlaf_pkg::PH_DONE;
					end
				end
			end
			nlaf_pkg::PH_REC_HDR: begin
				if (!hdr_good_d || past_end || left_q == 16'd0 || left_q > 16'd4) begin
					phase_d = nlaf_pkg::PH_DONE;
				end else begin
					case (idx)
						2'd0: full_len = {8'd0, b};
						2'd1: full_len = {b, rec_len_q[7:0]};
						2'd2: full_type = {8'd0, b};
						default: full_type = {b, rec_type_q[7:0]};
					endcase
					rec_len_d = full_len;
					rec_type_d = full_type;
					left_d = left_q - 16'd1;
					if (left_q == 16'd1) begin
						rec_end = 33'(o) - 33'd3 + 33'(full_len);
						rounded = ((17'(full_len) + 17'd3) >> 2) << 2;
						if (full_len < 16'd4 || rec_end > 33'(decl_len_d)) begin
							phase_d = nlaf_pkg::PH_DONE;
						end else if (full_type[13:0] == wanted_type) begin
							match_seen_d = 1'b1;
							match_len_d = full_len - 16'd4;
							left_d = full_len - 16'd4;
							if (full_len == 16'd4) begin
								match_done_d = 1'b1;
								phase_d = nlaf_pkg::PH_DONE;
							end else begin
								phase_d = nlaf_pkg::PH_MATCH;
							end
						end else if (rounded == 17'd4) begin
							left_d = 16'd4;
							phase_d = nlaf_pkg::PH_REC_HDR;
						end else begin
							left_d = 16'(rounded - 17'd4);
							phase_d = nlaf_pkg::PH_SKIP;
						end
					end
				end
			end
			nlaf_pkg::PH_SKIP: begin
				if (past_end || left_q == 16'd0) begin
					phase_d = nlaf_pkg::PH_DONE;
				end else begin
					left_d = left_q - 16'd1;
					if (left_q == 16'd1) begin
						left_d = 16'd4;
						phase_d = nlaf_pkg::PH_REC_HDR;
					end
				end
			end
			nlaf_pkg::PH_MATCH: begin
				if (past_end || left_q == 16'd0 || left_q > match_len_q) begin
					phase_d = nlaf_pkg::PH_DONE;
				end else begin
					vv = (match_len_q - left_q) < max_copy;
					left_d = left_q - 16'd1;
					if (left_q == 16'd1) begin
						match_done_d = 1'b1;
						phase_d = nlaf_pkg::PH_DONE;
					end
				end
			end
			default: phase_d = nlaf_pkg::PH_DONE;
		endcase
	end

	assign emit = take && (vv || q_item.last_byte);
	assign found_w = q_item.last_byte && hdr_good_d && match_seen_d && match_done_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= nlaf_pkg::PH_HEADER;
			decl_len_q <= '0;
			hdr_good_q <= 1'b0;
			rec_len_q <= '0;
			rec_type_q <= '0;
			left_q <= '0;
			match_seen_q <= 1'b0;
			match_done_q <= 1'b0;
			match_len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (q_item.last_byte) begin
					phase_q <= nlaf_pkg::PH_HEADER;
					decl_len_q <= '0;
					hdr_good_q <= 1'b0;
					rec_len_q <= '0;
					rec_type_q <= '0;
					left_q <= '0;
					match_seen_q <= 1'b0;
					match_done_q <= 1'b0;
					match_len_q <= '0;
				end else begin
					phase_q <= phase_d;
					decl_len_q <= decl_len_d;
					hdr_good_q <= hdr_good_d;
					rec_len_q <= rec_len_d;
					rec_type_q <= rec_type_d;
					left_q <= left_d;
					match_seen_q <= match_seen_d;
					match_done_q <= match_done_d;
					match_len_q <= match_len_d;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.value_byte <= vv ? b : 8'd0;
			out_q.value_valid <= vv;
			out_q.done_res <= q_item.last_byte;
			out_q.header_ok <= q_item.last_byte && hdr_good_d;
			out_q.found <= found_w;
			out_q.value_length <= found_w ? match_len_d : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	a_found_needs_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.found) |-> (out_item.header_ok && out_item.done_res))
		else $error("found without good header");
	a_match_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == nlaf_pkg::PH_MATCH) |-> (match_seen_q && hdr_good_q))
		else $error("match phase without a match");
	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");

endmodule

// ===== rtl/netlink_attribute_finder.sv =====
// Top level of the generic netlink attribute finder.
// Depends on nlaf_pkg, nlaf_front, nlaf_queue and nlaf_back.
// Takes one message byte per cycle while in_ready is high, and gives at most one result
// per byte: a value byte of the first attribute whose type matches wanted_type, and a
// status on the last byte. The record walk in the back end updates its counters once
// per byte, one byte per cycle unless the output stalls. A four-entry queue lets the
// front end keep accepting while the output is stalled. Value bytes are tentative until
// found is reported. Registers must be written only between messages; unchecked.
module netlink_attribute_finder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nlaf_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output nlaf_pkg::out_item_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [13:0] wanted_type_q;
	logic [7:0]  user_hdr_len_q;
	logic [15:0] max_copy_q;

	logic                   fq_valid, fq_ready;
	nlaf_pkg::tagged_byte_t fq_item;
	logic                   qb_valid, qb_ready;
	nlaf_pkg::tagged_byte_t qb_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_type_q <= '0;
			user_hdr_len_q <= '0;
			max_copy_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				nlaf_pkg::CFG_WANTED_TYPE: wanted_type_q <= cfg_data[13:0];
				nlaf_pkg::CFG_USER_HDR_LEN: user_hdr_len_q <= cfg_data[7:0];
				nlaf_pkg::CFG_MAX_COPY: max_copy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	nlaf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
	);

	nlaf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_item(qb_item)
	);

	nlaf_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(qb_valid), .q_ready(qb_ready), .q_item(qb_item),
		.wanted_type(wanted_type_q), .user_header_len(user_hdr_len_q),
		.max_copy(max_copy_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

endmodule

// ===== verif/testbench.sv =====
// Testbench for netlink_attribute_finder: drives generic netlink messages byte by byte
// and checks every result against a predictor of the attribute walk. Depends on nlaf_pkg.
`timescale 1ns / 100ps

import nlaf_pkg::*;

class attr_scoreboard;
	// register copies
	logic [13:0] want_type;
	logic [7:0]  uhdr_len;
	logic [15:0] copy_limit;
	// message state
	logic [31:0] offset;
	logic [31:0] decl_len;
	logic        hdr_good;
	walk_phase_t phase;
	logic [15:0] rec_len;
	logic [15:0] rec_type;
	logic [15:0] left;
	logic        m_seen;
	logic        m_done;
	logic [15:0] m_len;
	out_item_t   pending[$];
	int          mismatches;

	function new();
		want_type = 0;
		uhdr_len = 0;
		copy_limit = 16'hFFFF;
		mismatches = 0;
		clear_msg();
	endfunction

	function void clear_msg();
		offset = 0;
		decl_len = 0;
		hdr_good = 0;
		phase = PH_HEADER;
		rec_len = 0;
		rec_type = 0;
		left = 0;
		m_seen = 0;
		m_done = 0;
		m_len = 0;
	endfunction

	function void write_reg(cfg_index_t idx, logic [15:0] val);
		case (idx)
			CFG_WANTED_TYPE: want_type = val[13:0];
			CFG_USER_HDR_LEN: uhdr_len = val[7:0];
			CFG_MAX_COPY: copy_limit = val;
			default: ;
		endcase
	endfunction

	function void note_input(in_item_t it);
		longint unsigned o, attr_at, rstart;
		logic [16:0] step;
		logic vv;
		logic [7:0] vb;
		out_item_t r;
		o = offset;
		vv = 0;
		vb = 0;
		attr_at = FIXED_HDR_BYTES + ((uhdr_len + 3) & ~3);
		if (o < 4) decl_len = decl_len | (32'(it.msg_byte) << (8 * o));
		if (o == 3) hdr_good = decl_len >= attr_at;
		case (phase)
			PH_HEADER: begin
				if (o + 1 >= attr_at && o >= 3) begin
					if (hdr_good) begin
						phase = PH_REC_HDR;
						left = 4;
						rec_len = 0;
						rec_type = 0;
					end else
						phase = PH_DONE;
				end
			end
			PH_REC_HDR: begin
				if (!hdr_good || o >= decl_len || left == 0 || left > 4)
					phase = PH_DONE;
				else begin
					case (4 - left)
						0: rec_len = it.msg_byte;
						1: rec_len[15:8] = it.msg_byte;
						2: rec_type = it.msg_byte;
						default: rec_type[15:8] = it.msg_byte;
					endcase
					left--;
					if (left == 0) begin
						rstart = o - 3;
						if (rec_len < 4 || rstart + rec_len > decl_len)
							phase = PH_DONE;
						else if (rec_type[13:0] == want_type) begin
							m_seen = 1;
							m_len = rec_len - 4;
							left = m_len;
							if (m_len == 0) begin
								m_done = 1;
								phase = PH_DONE;
							end else
								phase = PH_MATCH;
						end else begin
							step = (17'(rec_len) + 17'd3) & ~17'd3;
							left = 16'(step - 17'd4);
							if (left == 0) begin
								left = 4;
								phase = PH_REC_HDR;
							end else
								phase = PH_SKIP;
						end
					end
				end
			end
			PH_SKIP: begin
				if (o >= decl_len || left == 0)
					phase = PH_DONE;
				else begin
					left--;
					if (left == 0) begin
						left = 4;
						phase = PH_REC_HDR;
					end
				end
			end
			PH_MATCH: begin
				if (o >= decl_len || left == 0 || left > m_len)
					phase = PH_DONE;
				else begin
					if (m_len - left < copy_limit) begin
						vv = 1;
						vb = it.msg_byte;
					end
					left--;
					if (left == 0) begin
						m_done = 1;
						phase = PH_DONE;
					end
				end
			end
			default: phase = PH_DONE;
		endcase
		if (offset != 32'hFFFF_FFFF) offset++;
		if (vv || it.last_byte) begin
			r.value_byte = vb;
			r.value_valid = vv;
			r.done_res = it.last_byte;
			r.header_ok = it.last_byte && hdr_good;
			r.found = it.last_byte && hdr_good && m_seen && m_done;
			r.value_length = r.found ? m_len : 16'd0;
			pending.push_back(r);
			if (it.last_byte) clear_msg();
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t exp;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		exp = pending.pop_front();
		if (got.value_byte !== exp.value_byte || got.value_valid !== exp.value_valid ||
		    got.done_res !== exp.done_res || got.header_ok !== exp.header_ok ||
		    got.found !== exp.found || got.value_length !== exp.value_length) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected %h actual %h", exp, got);
		end
	endfunction
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_item;
	logic out_valid;
	logic out_ready;
	out_item_t out_item;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	attr_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off;
	int hold_req;
	int hold_seen;
	int cycles;
	int msg_sent;
	byte unsigned msg_buf[$];

	netlink_attribute_finder u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver: random stalls plus a long hold-off when one is requested.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 0;
			hold_off <= 0;
			hold_seen <= 0;
		end else begin
			if (out_valid && out_ready) sb.check_result(out_item);
			if (hold_req != hold_seen) begin
				hold_seen <= hold_req;
				hold_off <= 200;
				out_ready <= 0;
			end else if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 0;
			end else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_byte(byte unsigned b, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_item <= '{msg_byte: b, last_byte: last};
		do @(posedge clk); while (!in_ready);
		sb.note_input('{msg_byte: b, last_byte: last});
		msg_sent++;
	endtask

	task automatic send_msg();
		for (int i = 0; i < msg_buf.size(); i++) send_byte(msg_buf[i], i == msg_buf.size() - 1);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.write_reg(idx, val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic put16(int v);
		msg_buf.push_back(8'(v & 8'hFF));
		msg_buf.push_back(8'((v >> 8) & 8'hFF));
	endtask

	// Builds a message: headers, user header, attributes; some may match.
	// Mode 0 well formed, 1 truncated, 2 bad length field, 3 short header.
	task automatic build_msg(int mode, int plen_max);
		int total, nattr, ulen, plen, rl, ty, cut;
		msg_buf.delete();
		ulen = (sb.uhdr_len + 3) & ~3;
		repeat (16) msg_buf.push_back(8'($urandom_range(255)));
		repeat (4 + ulen) msg_buf.push_back(8'($urandom_range(255)));
		nattr = $urandom_range(4);
		for (int a = 0; a < nattr; a++) begin
			plen = $urandom_range(plen_max);
			rl = plen + 4;
			if (mode == 2 && $urandom_range(2) == 0) rl = $urandom_range(3);
			ty = ($urandom_range(2) == 0) ? sb.want_type : $urandom_range(16'h3FFF);
			ty = ty | ($urandom_range(3) << 14);
			put16(rl);
			put16(ty);
			repeat (plen) msg_buf.push_back(8'($urandom_range(255)));
			while (msg_buf.size() % 4 != 0) msg_buf.push_back(8'($urandom_range(255)));
		end
		total = msg_buf.size();
		if (mode == 3) total = $urandom_range(20 + ulen - 1);
		msg_buf[0] = 8'(total & 8'hFF);
		msg_buf[1] = 8'((total >> 8) & 8'hFF);
		msg_buf[2] = 0;
		msg_buf[3] = 0;
		if (mode == 1) begin
			cut = $urandom_range(msg_buf.size() - 1) + 1;
			while (msg_buf.size() > cut) void'(msg_buf.pop_back());
		end else if ($urandom_range(4) == 0)
			repeat ($urandom_range(6)) msg_buf.push_back(8'($urandom_range(255)));
	endtask

	task automatic random_phase(int n);
		int start;
		start = msg_sent;
		while (msg_sent - start < n) begin
			build_msg(($urandom_range(9) < 7) ? 0 : $urandom_range(3) + 0, 12);
			send_msg();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		cfg_we = 0;
		cfg_index = CFG_WANTED_TYPE;
		cfg_data = 0;
		hold_req = 0;
		msg_sent = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: single byte message, short header, all-ones bytes, zero-length attribute.
		msg_buf = {8'hFF};
		send_msg();
		msg_buf = {8'h00, 8'h00, 8'h00, 8'h00};
		send_msg();
		msg_buf = {8'h18, 0, 0, 0, 0,0,0,0, 0,0,0,0, 0,0,0,0, 0,0,0,0, 8'h04, 0, 8'hC0, 0};
		send_msg();
		msg_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_msg();
		write_reg(CFG_WANTED_TYPE, 16'h3FFF);
		write_reg(CFG_MAX_COPY, 16'd0);
		build_msg(0, 8);
		send_msg();

		// Sender idles seldom at first, receiver half the time.
		send_idle_pct = 17;
		recv_idle_pct = 50;
		write_reg(CFG_MAX_COPY, 16'd3);
		write_reg(CFG_USER_HDR_LEN, 16'd255);
		write_reg(CFG_WANTED_TYPE, 16'd5);
		random_phase(250);
		send_idle_pct = 50;
		recv_idle_pct = 17;
		write_reg(CFG_USER_HDR_LEN, 16'd0);
		write_reg(CFG_WANTED_TYPE, 16'd0);
		write_reg(CFG_MAX_COPY, 16'hFFFF);
		random_phase(150);
		write_reg(CFG_USER_HDR_LEN, 16'd7);
		write_reg(CFG_WANTED_TYPE, $urandom_range(16'h3FFF));
		random_phase(100);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(CFG_USER_HDR_LEN, 16'd1);
		write_reg(CFG_WANTED_TYPE, 16'd9);
		write_reg(CFG_MAX_COPY, 16'd1);
		hold_req++;
		random_phase(250);

		drain();
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
